### src/mss_pkg.sv
// Shared types and constants of the microtonal step sequencer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mss_pkg;

  // Fixed field widths.
  localparam int PitchIdxW = 5;
  localparam int VoltW     = 20;
  localparam int UnitW     = 11;
  localparam int MagW      = 19;
  localparam int ShownW    = 4;
  localparam int CfgW      = 20;
  localparam int CfgIdxW   = 3;
  localparam int OutLanes  = 3;

  // One memory lane holds the gate bit above the pitch index.
  localparam int LaneW = PitchIdxW + 1;
  localparam logic [LaneW-1:0] LaneReset = {1'b1, {PitchIdxW{1'b0}}};

  // Clamp limit, four volts in Q16.
  localparam logic signed [VoltW:0] VoltLimit = 21'sd262144;

  // (8192 * a + 4) / 9 = 910 * a + (2 * a + 4) / 9, the small quotient by reciprocal.
  localparam logic [MagW-1:0] Div9Whole = 19'd910;
  localparam logic [21:0]     Div9Recip = 22'd1821;
  localparam int              Div9Shift = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStepCount,
    CfgStepPeriod,
    CfgBaseOctave,
    CfgBaseNote,
    CfgTune,
    CfgIntervalMode,
    CfgExtClock
  } cfg_idx_e;

  typedef enum logic [1:0] {
    IntSemitone,
    IntQuarter,
    IntTwelfth
  } interval_e;

  localparam logic ModeTick  = 1'b0;
  localparam logic ModeWrite = 1'b1;

  typedef struct packed {
    logic              running;
    logic              adv;
    logic [ShownW-1:0] shown;
  } tick_info_t;

endpackage

`default_nettype wire

### src/mss_step_mem.sv
// Step table memory: one row per step, one lane per track, two read ports.
// Includes the clearing sweep after reset. Depends on mss_pkg.
`default_nettype none

module mss_step_mem #(
  parameter int STEPS_MAX = 16,
  parameter int TRACKS    = 3,
  localparam int StepW    = (STEPS_MAX > 1) ? $clog2(STEPS_MAX) : 1,
  localparam int RowW     = TRACKS * mss_pkg::LaneW
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [StepW-1:0]            wr_step_i,
  input  wire logic [1:0]                  wr_track_i,
  input  wire logic [mss_pkg::LaneW-1:0]   wr_word_i,
  input  wire logic                        rd_en_i,
  input  wire logic [StepW-1:0]            rd_addr_a_i,
  input  wire logic [StepW-1:0]            rd_addr_b_i,
  output logic      [RowW-1:0]             rd_data_a_o,
  output logic      [RowW-1:0]             rd_data_b_o,
  output logic                             busy_o
);

  logic [RowW-1:0]  mem_q [STEPS_MAX];
  logic [RowW-1:0]  rd_a_q, rd_b_q;
  logic [StepW-1:0] clr_row_q, clr_row_d;
  logic             busy_q, busy_d;
  logic [TRACKS-1:0] lane_sel;

  always_comb begin
    for (int t = 0; t < TRACKS; t++) begin
      lane_sel[t] = (int'(wr_track_i) == t);
    end
  end

  // Sweep every row to the reset contents before the first item.
  always_comb begin
    busy_d    = busy_q;
    clr_row_d = clr_row_q;
    if (busy_q) begin
      if (clr_row_q == StepW'(STEPS_MAX - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_row_d = clr_row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_row_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_row_q <= clr_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_row_q] <= {TRACKS{mss_pkg::LaneReset}};
    end else if (wr_en_i) begin
      for (int t = 0; t < TRACKS; t++) begin
        if (lane_sel[t]) begin
          mem_q[wr_step_i][t*mss_pkg::LaneW +: mss_pkg::LaneW] <= wr_word_i;
        end
      end
    end
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;
  assign busy_o      = busy_q;

endmodule

`default_nettype wire

### src/mss_ctrl.sv
// Step position control: elapsed counter, clock and reset edge detection.
// Produces the memory addresses and the per-tick control. Depends on mss_pkg.
`default_nettype none

module mss_ctrl #(
  parameter int STEPS_MAX = 16,
  localparam int StepW    = (STEPS_MAX > 1) ? $clog2(STEPS_MAX) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 tick_i,
  input  wire logic                 running_i,
  input  wire logic                 clock_level_i,
  input  wire logic                 reset_level_i,
  input  wire logic                 reset_button_i,
  input  wire logic [4:0]           step_count_i,
  input  wire logic [19:0]          period_i,
  input  wire logic                 ext_clock_i,
  output logic      [StepW-1:0]     pitch_addr_o,
  output logic      [StepW-1:0]     gate_addr_o,
  output mss_pkg::tick_info_t       info_o
);

  localparam int CmpW = (StepW + 1 > 5) ? StepW + 1 : 5;

  logic [StepW-1:0] step_q, step_d, wrap_step;
  logic [19:0]      elapsed_q, elapsed_d, elapsed_inc;
  logic             prev_clk_q, prev_clk_d;
  logic             prev_rlev_q, prev_rbtn_q;
  logic             adv, rst_edge;
  logic [CmpW-1:0]  cnt_eff, nxt;

  // Step after an advance, wrapped at the effective step count.
  always_comb begin
    cnt_eff = (CmpW'(step_count_i) > CmpW'(STEPS_MAX)) ? CmpW'(STEPS_MAX)
                                                       : CmpW'(step_count_i);
    nxt       = CmpW'(step_q) + 1'b1;
    wrap_step = (nxt >= cnt_eff) ? '0 : nxt[StepW-1:0];
  end

  always_comb begin
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
    elapsed_d   = elapsed_inc;
    prev_clk_d  = prev_clk_q;
    adv         = 1'b0;
    if (running_i) begin
      if (!ext_clock_i) begin
        if (elapsed_inc >= period_i) begin
          elapsed_d = '0;
          adv       = 1'b1;
        end
      end else begin
        adv        = clock_level_i & ~prev_clk_q;
        prev_clk_d = clock_level_i;
      end
    end
    rst_edge = (reset_level_i & ~prev_rlev_q) | (reset_button_i & ~prev_rbtn_q);
    step_d   = rst_edge ? '0 : (adv ? wrap_step : step_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      elapsed_q   <= '0;
      prev_clk_q  <= 1'b0;
      prev_rlev_q <= 1'b0;
      prev_rbtn_q <= 1'b0;
    end else if (tick_i) begin
      step_q      <= step_d;
      elapsed_q   <= elapsed_d;
      prev_clk_q  <= prev_clk_d;
      prev_rlev_q <= reset_level_i;
      prev_rbtn_q <= reset_button_i;
    end
  end

  assign pitch_addr_o   = step_q;
  assign gate_addr_o    = wrap_step;
  assign info_o.running = running_i;
  assign info_o.adv     = adv;
  assign info_o.shown   = mss_pkg::ShownW'(step_q);

endmodule

`default_nettype wire

### src/mss_pitch.sv
// Pitch to voltage lane: unit sum and rounded scaling by 8192/9 into a register,
// then sign, tuning offset and clamp. Depends on mss_pkg.
`default_nettype none

module mss_pitch (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic        [mss_pkg::PitchIdxW-1:0] idx_i,
  input  wire logic signed [mss_pkg::UnitW-1:0]     base_units_i,
  input  wire logic        [1:0]                    imode_i,
  input  wire logic signed [12:0]                   tune_i,
  output logic      signed [mss_pkg::VoltW-1:0]     volts_o
);

  logic        [2:0]                k;
  logic        [7:0]                step_units;
  logic signed [mss_pkg::UnitW-1:0] units, units_abs;
  logic        [8:0]                a;
  logic        [10:0]               y;
  logic        [21:0]               corr_prod;
  logic        [mss_pkg::MagW-1:0]  mag, mag_q;
  logic                             neg_q;
  logic signed [mss_pkg::VoltW:0]   mag_s, q, v;

  always_comb begin
    unique case (imode_i)
      mss_pkg::IntSemitone: k = 3'd6;
      mss_pkg::IntQuarter:  k = 3'd3;
      default:              k = 3'd1;
    endcase
    step_units = 8'(idx_i) * 8'(k);
    units      = base_units_i + $signed({3'b000, step_units});
    units_abs  = units[mss_pkg::UnitW-1] ? -units : units;
    a          = units_abs[8:0];
    y          = {1'b0, a, 1'b0} + 11'd4;
    corr_prod  = 22'(y) * mss_pkg::Div9Recip;
    mag        = mss_pkg::MagW'(a) * mss_pkg::Div9Whole
               + mss_pkg::MagW'(corr_prod[21:mss_pkg::Div9Shift]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag;
      neg_q <= units[mss_pkg::UnitW-1];
    end
  end

  always_comb begin
    mag_s = $signed({2'b00, mag_q});
    q     = neg_q ? -mag_s : mag_s;
    v     = q + (mss_pkg::VoltW + 1)'(tune_i);
    if (v > mss_pkg::VoltLimit) begin
      v = mss_pkg::VoltLimit;
    end else if (v < -mss_pkg::VoltLimit) begin
      v = -mss_pkg::VoltLimit;
    end
    volts_o = v[mss_pkg::VoltW-1:0];
  end

endmodule

`default_nettype wire

### src/microtonal_step_sequencer_top.sv
// Microtonal step sequencer, top level: three output tracks of up to STEPS_MAX steps.
// A tick item's result passes through stage A, stage B and the output register in turn.
// Throughput: one item per cycle while the output is not stalled and the table is not being cleared.
// Reset: control state clears at once, then a sweep over every row loads the step
// table (gate set, pitch zero), during which no item is accepted; configuration is taken.
`default_nettype none

module microtonal_step_sequencer_top #(
  parameter int STEPS_MAX = 16,
  parameter int TRACKS    = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port.
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [19:0]         cfg_data_i,
  // Input channel.
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                mode_i,
  input  wire logic                running_i,
  input  wire logic                clock_level_i,
  input  wire logic                reset_level_i,
  input  wire logic                reset_button_i,
  input  wire logic [3:0]          entry_step_i,
  input  wire logic [1:0]          entry_track_i,
  input  wire logic [4:0]          entry_pitch_i,
  input  wire logic                entry_gate_i,
  // Output channel.
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [19:0]       pitch_a_o,
  output logic signed [19:0]       pitch_b_o,
  output logic signed [19:0]       pitch_c_o,
  output logic                     gate_a_o,
  output logic                     gate_b_o,
  output logic                     gate_c_o,
  output logic [3:0]               shown_step_o,
  output logic                     play_light_o
);

  localparam int StepW = (STEPS_MAX > 1) ? $clog2(STEPS_MAX) : 1;
  localparam int RowW  = TRACKS * mss_pkg::LaneW;
  // Only the first three tracks reach the outputs.
  localparam int Lanes = (TRACKS < mss_pkg::OutLanes) ? TRACKS : mss_pkg::OutLanes;

  // ------------------------------------------------------------------
  // Configuration registers. They are to be written only while the block is
  // idle (the block does not enforce it), so later pipeline stages may read them directly.
  // ------------------------------------------------------------------
  logic        [4:0]  step_count_q;
  logic        [19:0] period_q;
  logic signed [2:0]  octave_q;
  logic        [3:0]  note_q;
  logic signed [12:0] tune_q;
  logic        [1:0]  imode_q;
  logic               ext_clock_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= 5'd16;
      period_q     <= 20'd6000;
      octave_q     <= '0;
      note_q       <= '0;
      tune_q       <= '0;
      imode_q      <= mss_pkg::IntSemitone;
      ext_clock_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mss_pkg::CfgStepCount:    step_count_q <= cfg_data_i[4:0];
        mss_pkg::CfgStepPeriod:   period_q     <= cfg_data_i;
        mss_pkg::CfgBaseOctave:   octave_q     <= $signed(cfg_data_i[2:0]);
        mss_pkg::CfgBaseNote:     note_q       <= cfg_data_i[3:0];
        mss_pkg::CfgTune:         tune_q       <= $signed(cfg_data_i[12:0]);
        mss_pkg::CfgIntervalMode: imode_q      <= cfg_data_i[1:0];
        mss_pkg::CfgExtClock:     ext_clock_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Base note in 1/72 octave units: 6 * (12 * octave + note - 9), shared by all lanes.
  logic signed [mss_pkg::UnitW-1:0] semis, base_units;

  always_comb begin
    semis      = 11'sd12 * mss_pkg::UnitW'(octave_q) + $signed({7'b0, note_q}) - 11'sd9;
    base_units = 11'sd6 * semis;
  end

  // ------------------------------------------------------------------
  // Pipeline flow. Stage A holds the memory read data, stage B the scaled
  // magnitudes, and the output register the result item. Each stage moves
  // when the one after it is empty or moving, so a waiting result does not
  // hold up items behind it while bubbles remain.
  // ------------------------------------------------------------------
  logic a_valid_q, b_valid_q, out_valid_q;
  logic en_a, en_b, en_o;
  logic mem_busy;
  logic in_acc, tick_acc, wr_acc;

  assign en_o = !out_valid_q || !out_stall_i;
  assign en_b = !b_valid_q || en_o;
  assign en_a = !a_valid_q || en_b;

  assign in_stall_o = mem_busy || !en_a;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (mode_i == mss_pkg::ModeTick);
  // A write outside the step or track range is dropped.
  assign wr_acc     = in_acc && (mode_i == mss_pkg::ModeWrite)
                    && (int'(entry_step_i) < STEPS_MAX) && (int'(entry_track_i) < TRACKS);

  // ------------------------------------------------------------------
  // Step control and the step table.
  // ------------------------------------------------------------------
  logic [StepW-1:0]    pitch_addr, gate_addr;
  mss_pkg::tick_info_t tick_info, a_info_q, b_info_q;
  logic [RowW-1:0]     rd_pitch_row, rd_gate_row;

  mss_ctrl #(
    .STEPS_MAX (STEPS_MAX)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (tick_acc),
    .running_i      (running_i),
    .clock_level_i  (clock_level_i),
    .reset_level_i  (reset_level_i),
    .reset_button_i (reset_button_i),
    .step_count_i   (step_count_q),
    .period_i       (period_q),
    .ext_clock_i    (ext_clock_q),
    .pitch_addr_o   (pitch_addr),
    .gate_addr_o    (gate_addr),
    .info_o         (tick_info)
  );

  // Pitch comes from the step before the advance, the gate from the step after it.
  mss_step_mem #(
    .STEPS_MAX (STEPS_MAX),
    .TRACKS    (TRACKS)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_acc),
    .wr_step_i   (StepW'(entry_step_i)),
    .wr_track_i  (entry_track_i),
    .wr_word_i   ({entry_gate_i, entry_pitch_i}),
    .rd_en_i     (en_a),
    .rd_addr_a_i (pitch_addr),
    .rd_addr_b_i (gate_addr),
    .rd_data_a_o (rd_pitch_row),
    .rd_data_b_o (rd_gate_row),
    .busy_o      (mem_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid_q <= tick_acc;
      end
      if (en_b) begin
        b_valid_q <= a_valid_q;
      end
      if (en_o) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_info_q <= tick_info;
    end
    if (en_b) begin
      b_info_q <= a_info_q;
    end
  end

  // ------------------------------------------------------------------
  // Per-lane pitch arithmetic and gate capture. The output registers also
  // serve as the held values that a paused tick repeats.
  // ------------------------------------------------------------------
  logic signed [mss_pkg::VoltW-1:0] lane_volts [Lanes];
  logic signed [mss_pkg::VoltW-1:0] pitch_q    [Lanes];
  logic        [Lanes-1:0]          b_gate_q, gate_q;
  logic        [Lanes-1:0]          a_gate;
  logic [mss_pkg::ShownW-1:0]       shown_q;
  logic                             play_q;

  for (genvar t = 0; t < Lanes; t++) begin : g_lane
    assign a_gate[t] = a_info_q.adv
                     & rd_gate_row[t*mss_pkg::LaneW + mss_pkg::PitchIdxW];

    mss_pitch u_pitch (
      .clk_i        (clk_i),
      .en_i         (en_b),
      .idx_i        (rd_pitch_row[t*mss_pkg::LaneW +: mss_pkg::PitchIdxW]),
      .base_units_i (base_units),
      .imode_i      (imode_q),
      .tune_i       (tune_q),
      .volts_o      (lane_volts[t])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_gate_q <= a_gate;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < Lanes; t++) begin
        pitch_q[t] <= '0;
      end
      gate_q  <= '0;
      shown_q <= '0;
      play_q  <= 1'b0;
    end else if (en_o && b_valid_q) begin
      shown_q <= b_info_q.shown;
      play_q  <= b_info_q.running;
      if (b_info_q.running) begin
        for (int t = 0; t < Lanes; t++) begin
          pitch_q[t] <= lane_volts[t];
        end
        gate_q <= b_gate_q;
      end
    end
  end

  // Tracks beyond the configured count read as zero.
  logic signed [mss_pkg::VoltW-1:0] out_pitch [mss_pkg::OutLanes];
  logic        [mss_pkg::OutLanes-1:0] out_gate;

  for (genvar k = 0; k < mss_pkg::OutLanes; k++) begin : g_out
    if (k < Lanes) begin : g_used
      assign out_pitch[k] = pitch_q[k];
      assign out_gate[k]  = gate_q[k];
    end else begin : g_unused
      assign out_pitch[k] = '0;
      assign out_gate[k]  = 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pitch_a_o    = out_pitch[0];
  assign pitch_b_o    = out_pitch[1];
  assign pitch_c_o    = out_pitch[2];
  assign gate_a_o     = out_gate[0];
  assign gate_b_o     = out_gate[1];
  assign gate_c_o     = out_gate[2];
  assign shown_step_o = shown_q;
  assign play_light_o = play_q;

`ifndef ASSERT_OFF
  // An accepted tick always lands in stage A, in step with its memory read.
  a_tick_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> a_valid_q)
    else $error("accepted tick did not enter stage A");

  // A blocked stage A keeps its control alongside the held read data.
  a_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !en_b) |=> (a_valid_q && $stable(a_info_q)))
    else $error("stage A changed while blocked");

  // Nothing is accepted while the table is being cleared.
  no_item_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> !in_acc)
    else $error("item accepted during table clear");

  // A result moving out of stage B always becomes an output item.
  b_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && en_o) |=> out_valid_q)
    else $error("result lost between stage B and output");
`endif

endmodule

`default_nettype wire
